>>> hdl/scev_pkg.sv
// ----------------------------------------------------------------------------
// scev_pkg
// shared types and constants for the scancode event stack
// ----------------------------------------------------------------------------
package scev_pkg;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] KC_LSHIFT   = 7'h2A;
    localparam logic [6:0] KC_RSHIFT   = 7'h36;
    localparam logic [6:0] KC_CTRL     = 7'h1D;
    localparam logic [6:0] KC_ALT      = 7'h38;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic       extended;
        logic       shift_held;
        logic       alt_held;
        logic       ctrl_held;
        logic       released;
        logic [6:0] key_code;
    } event_t;

    typedef struct packed {
        op_t    op;
        event_t evt;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] scan_byte;
    } req_t;

    typedef struct packed {
        logic       event_valid;
        logic [6:0] key_code;
        logic       released;
        logic       ctrl_held;
        logic       alt_held;
        logic       shift_held;
        logic       extended;
        logic       events_waiting;
    } rsp_t;

endpackage

>>> hdl/scev_front.sv
// ----------------------------------------------------------------------------
// scev_front
// decodes request words, tracks prefix and modifier keys, issues commands
// ----------------------------------------------------------------------------
module scev_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  scev_pkg::req_t req,
    input  logic           q_full,
    output logic           req_stall,
    output logic           cmd_push,
    output scev_pkg::cmd_t cmd
);

    logic prefix_reg, prefix_next;
    logic ctrl_reg, ctrl_next;
    logic alt_reg, alt_next;
    logic shift_reg, shift_next;
    logic accept;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;
    assign cmd_push  = accept;

    always_comb
    begin
        prefix_next = prefix_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        shift_next  = shift_reg;

        cmd.op             = scev_pkg::OP_NONE;
        cmd.evt.extended   = prefix_reg;
        cmd.evt.shift_held = shift_reg;
        cmd.evt.alt_held   = alt_reg;
        cmd.evt.ctrl_held  = ctrl_reg;
        cmd.evt.released   = req.scan_byte[7];
        cmd.evt.key_code   = req.scan_byte[6:0];

        unique case (req.mode)
            scev_pkg::MODE_BYTE:
            begin
                if (!prefix_reg && req.scan_byte == scev_pkg::PREFIX_BYTE)
                begin
                    prefix_next = 1'b1;
                end
                else
                begin
                    prefix_next = 1'b0;
                    if (req.scan_byte[6:0] == scev_pkg::KC_LSHIFT ||
                        req.scan_byte[6:0] == scev_pkg::KC_RSHIFT)
                    begin
                        shift_next = !req.scan_byte[7];
                    end
                    else if (req.scan_byte[6:0] == scev_pkg::KC_CTRL)
                    begin
                        ctrl_next = !req.scan_byte[7];
                    end
                    else if (req.scan_byte[6:0] == scev_pkg::KC_ALT)
                    begin
                        alt_next = !req.scan_byte[7];
                    end
                    else
                    begin
                        cmd.op = scev_pkg::OP_PUSH;
                    end
                end
            end
            scev_pkg::MODE_POP:   cmd.op = scev_pkg::OP_POP;
            scev_pkg::MODE_CLEAR: cmd.op = scev_pkg::OP_CLEAR;
            default:              cmd.op = scev_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
            ctrl_reg   <= 1'b0;
            alt_reg    <= 1'b0;
            shift_reg  <= 1'b0;
        end
        else if (accept)
        begin
            prefix_reg <= prefix_next;
            ctrl_reg   <= ctrl_next;
            alt_reg    <= alt_next;
            shift_reg  <= shift_next;
        end
    end

endmodule

>>> hdl/scev_queue.sv
// ----------------------------------------------------------------------------
// scev_queue
// small command fifo between the decoder and the stack engine
// ----------------------------------------------------------------------------
module scev_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scev_pkg::cmd_t push_word,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output scev_pkg::cmd_t word
);

    localparam int PtrW = $clog2(scev_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(scev_pkg::QUEUE_DEPTH + 1);

    scev_pkg::cmd_t slot_reg [scev_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] head_reg, tail_reg;
    logic [CntW-1:0] fill_reg;

    assign full  = fill_reg == CntW'(scev_pkg::QUEUE_DEPTH);
    assign valid = fill_reg != '0;
    assign word  = slot_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= (tail_reg == PtrW'(scev_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : tail_reg + 1'b1;
            end
            if (pop)
            begin
                head_reg <= (head_reg == PtrW'(scev_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/scev_back.sv
// ----------------------------------------------------------------------------
// scev_back
// event stack engine: single-port stack memory, depth counter, result register
// ----------------------------------------------------------------------------
module scev_back
#(
    parameter int DEPTH = 512
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  scev_pkg::cmd_t q_word,
    output logic           q_pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output scev_pkg::rsp_t rsp
);

    localparam int CntW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam logic [CntW-1:0] CntMax = CntW'(DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic wait_reg, wait_next;
    logic out_valid_reg, out_valid_next;
    scev_pkg::rsp_t out_reg, out_next;

    scev_pkg::event_t stack_mem [DEPTH];
    scev_pkg::event_t rd_data_reg;

    logic out_free;
    logic take;
    logic mem_wr;
    logic mem_rd;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign take      = (state_reg == ST_IDLE) && q_valid && out_free;
    assign q_pop     = take;
    assign mem_wr    = take && q_word.op == scev_pkg::OP_PUSH && cnt_reg != CntMax;
    assign mem_rd    = take && q_word.op == scev_pkg::OP_POP && cnt_reg != '0;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            stack_mem[cnt_reg] <= q_word.evt;
        end
        if (mem_rd)
        begin
            rd_data_reg <= stack_mem[cnt_reg - 1'b1];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (q_word.op)
                        scev_pkg::OP_PUSH:
                        begin
                            if (cnt_reg != CntMax)
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        scev_pkg::OP_CLEAR: cnt_next = '0;
                        default:            cnt_next = cnt_reg;
                    endcase

                    if (mem_rd)
                    begin
                        // result comes out once the read data is back
                        cnt_next   = cnt_reg - 1'b1;
                        wait_next  = cnt_reg != CntW'(1);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '0;
                        out_next.events_waiting = cnt_next != '0;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.event_valid    = 1'b1;
                    out_next.key_code       = rd_data_reg.key_code;
                    out_next.released       = rd_data_reg.released;
                    out_next.ctrl_held      = rd_data_reg.ctrl_held;
                    out_next.alt_held       = rd_data_reg.alt_held;
                    out_next.shift_held     = rd_data_reg.shift_held;
                    out_next.extended       = rd_data_reg.extended;
                    out_next.events_waiting = wait_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_word.op == scev_pkg::OP_CLEAR) |=> cnt_reg == '0)
        else $error("clear did not empty the stack");

    a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_word.op == scev_pkg::OP_PUSH && cnt_reg == CntMax)
        |=> cnt_reg == $past(cnt_reg))
        else $error("push on a full stack changed the depth");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_word.op == scev_pkg::OP_POP && cnt_reg != '0)
        |=> (state_reg == ST_READ && cnt_reg == CntW'($past(cnt_reg) - 1'b1)))
        else $error("pop did not start a stack read");

    a_read_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && !out_free) |=> state_reg == ST_READ)
        else $error("pending pop result lost");
`endif

endmodule

>>> hdl/scancode_event_stack.sv
// ----------------------------------------------------------------------------
// scancode_event_stack
// scancode set 1 decoder feeding a lifo event stack
// ----------------------------------------------------------------------------
//  channel   valid       stall       word
//  request   req_valid   req_stall   req  (mode, scan_byte)
//  result    rsp_valid   rsp_stall   rsp  (event fields, events_waiting)
//
//  one result word per request word, in order
//  other words: registered in the command queue, then in the stack engine result register
//  pop of a stored event: also passes through the registered stack read;
//  the stack engine takes no command while that read is pending
//  reset clears modifiers, prefix, stack depth and queue; stack contents stay
//  a 4-word command queue lets the decoder run on while the result side stalls
// ----------------------------------------------------------------------------
module scancode_event_stack
#(
    parameter int DEPTH = 512
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  scev_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output scev_pkg::rsp_t rsp
);

    logic           cmd_push;
    scev_pkg::cmd_t cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    scev_pkg::cmd_t q_word;

    scev_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .q_full    (q_full),
        .req_stall (req_stall),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    scev_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_word (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .word      (q_word)
    );

    scev_back #(
        .DEPTH (DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

>>> sim/tb_scancode_event_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_event_stack
// self-checking bench for the scancode set 1 decoder and its lifo event stack.
// a queue of pending words feeds a clocked driver; every accepted request word
// updates a local decoder/stack predictor, and a clocked monitor checks each
// result word, field by field, against the oldest prediction. traffic runs in
// three throttling phases, includes a stack flood against a long result hold,
// and ends on a drain check or a watchdog.
// ----------------------------------------------------------------------------
module tb_scancode_event_stack;

    localparam int         STACK_DEPTH  = 512;
    localparam int         ITEMS        = 1050;
    localparam int         FLOOD_AT     = 300;
    localparam int         FLOOD_WORDS  = 540;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         WATCHDOG     = 2000;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef struct {
        scev_pkg::req_t word;
        bit             wait_empty;
    } pending_word_t;

    logic           clk       = 1'b0;
    logic           rst_n;
    logic           req_valid = 1'b0;
    logic           req_stall;
    scev_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    scev_pkg::rsp_t rsp;

    pending_word_t  pending_words[$];
    scev_pkg::rsp_t expected_results[$];

    int unsigned total_words   = 0;
    int unsigned accepted_reqs = 0;
    int unsigned flood_start   = 0;
    int unsigned idle_cycles   = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned mismatches    = 0;

    // decoder and stack state as seen by the predictor
    logic             prefix_seen = 1'b0;
    logic             ctrl_on     = 1'b0;
    logic             alt_on      = 1'b0;
    logic             shift_on    = 1'b0;
    scev_pkg::event_t stack_mem[STACK_DEPTH];
    int unsigned      stack_fill  = 0;

    scancode_event_stack #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic scev_pkg::rsp_t decode_scancode(input scev_pkg::req_t w);
        scev_pkg::rsp_t   r;
        logic             ext;
        scev_pkg::event_t e;
        r = '0;
        case (w.mode)
            scev_pkg::MODE_BYTE:
            begin
                if (!prefix_seen && w.scan_byte == scev_pkg::PREFIX_BYTE)
                    prefix_seen = 1'b1;
                else
                begin
                    ext = prefix_seen;
                    prefix_seen = 1'b0;
                    if (w.scan_byte[6:0] == scev_pkg::KC_LSHIFT
                        || w.scan_byte[6:0] == scev_pkg::KC_RSHIFT)
                        shift_on = !w.scan_byte[7];
                    else if (w.scan_byte[6:0] == scev_pkg::KC_CTRL)
                        ctrl_on = !w.scan_byte[7];
                    else if (w.scan_byte[6:0] == scev_pkg::KC_ALT)
                        alt_on = !w.scan_byte[7];
                    else if (stack_fill < STACK_DEPTH - 1)
                    begin
                        // full stack drops the event silently
                        e.key_code   = w.scan_byte[6:0];
                        e.released   = w.scan_byte[7];
                        e.ctrl_held  = ctrl_on;
                        e.alt_held   = alt_on;
                        e.shift_held = shift_on;
                        e.extended   = ext;
                        stack_mem[stack_fill] = e;
                        stack_fill++;
                    end
                end
            end
            scev_pkg::MODE_POP:
            begin
                if (stack_fill != 0)
                begin
                    stack_fill--;
                    e = stack_mem[stack_fill];
                    r.event_valid = 1'b1;
                    r.key_code    = e.key_code;
                    r.released    = e.released;
                    r.ctrl_held   = e.ctrl_held;
                    r.alt_held    = e.alt_held;
                    r.shift_held  = e.shift_held;
                    r.extended    = e.extended;
                end
            end
            scev_pkg::MODE_CLEAR:
                stack_fill = 0;
            default:
                ;
        endcase
        r.events_waiting = (stack_fill != 0);
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_word(input logic [1:0] mode, input logic [7:0] b,
                                       input bit wait_empty);
        pending_word_t p;
        p.word.mode      = mode;
        p.word.scan_byte = b;
        p.wait_empty     = wait_empty;
        pending_words.push_back(p);
    endfunction

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(255));
    endfunction

    // any byte that pushes an event: no modifier, no prefix
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = random_byte();
        while (b[6:0] == scev_pkg::KC_LSHIFT || b[6:0] == scev_pkg::KC_RSHIFT
               || b[6:0] == scev_pkg::KC_CTRL || b[6:0] == scev_pkg::KC_ALT
               || b[6:0] == scev_pkg::PREFIX_BYTE[6:0])
            b = random_byte();
        return b;
    endfunction

    function automatic logic [7:0] modifier_byte();
        logic [6:0] kc;
        logic       rel;
        case ($urandom_range(3))
            0:       kc = scev_pkg::KC_LSHIFT;
            1:       kc = scev_pkg::KC_RSHIFT;
            2:       kc = scev_pkg::KC_CTRL;
            default: kc = scev_pkg::KC_ALT;
        endcase
        rel = 1'($urandom_range(1));
        return {rel, kc};
    endfunction

    function automatic int unsigned phase_of(input int unsigned n);
        if (n < total_words / 3)
            return 0;
        else if (n < 2 * total_words / 3)
            return 1;
        return 2;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned   idle_pct;
        pending_word_t p;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_results.push_back(decode_scancode(req));
                accepted_reqs++;
            end
            case (phase_of(accepted_reqs))
                0:       idle_pct = 28;
                1:       idle_pct = 88;
                default: idle_pct = 0;
            endcase
            if (!req_valid || !req_stall)
            begin
                if (pending_words.size() != 0
                    && !(pending_words[0].wait_empty && expected_results.size() != 0)
                    && $urandom_range(99) >= idle_pct)
                begin
                    p = pending_words.pop_front();
                    req_valid <= 1'b1;
                    req       <= p.word;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver throttling
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned    stall_pct;
        scev_pkg::rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation waiting: 0x%0h", rsp);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("event_valid", 32'(want.event_valid),
                                  32'(rsp.event_valid));
                    compare_field("key_code", 32'(want.key_code), 32'(rsp.key_code));
                    compare_field("released", 32'(want.released), 32'(rsp.released));
                    compare_field("ctrl_held", 32'(want.ctrl_held), 32'(rsp.ctrl_held));
                    compare_field("alt_held", 32'(want.alt_held), 32'(rsp.alt_held));
                    compare_field("shift_held", 32'(want.shift_held),
                                  32'(rsp.shift_held));
                    compare_field("extended", 32'(want.extended), 32'(rsp.extended));
                    compare_field("events_waiting", 32'(want.events_waiting),
                                  32'(rsp.events_waiting));
                end
            end
            case (phase_of(accepted_reqs))
                0:       stall_pct = 88;
                1:       stall_pct = 28;
                default: stall_pct = 0;
            endcase
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && accepted_reqs > flood_start)
            begin
                // long hold while the flood keeps coming: queue fills, input stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned seg_len;
        int unsigned pick;
        int unsigned k;
        bit          flooded;
        logic [7:0]  b;
        rst_n = 1'b0;
        flooded = 1'b0;

        // directed: empty pop, unused mode, modifiers, prefixes, clear and pop
        queue_word(scev_pkg::MODE_POP, 8'h00, 1'b0);
        queue_word(MODE_UNUSED, 8'hFF, 1'b0);
        queue_word(scev_pkg::MODE_CLEAR, 8'hA5, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, 8'h00, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, 8'hFF, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b0, scev_pkg::KC_LSHIFT}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b0, scev_pkg::KC_CTRL}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b0, scev_pkg::KC_ALT}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, 8'h10, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, scev_pkg::PREFIX_BYTE, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, scev_pkg::PREFIX_BYTE, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, scev_pkg::PREFIX_BYTE, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b1, scev_pkg::KC_CTRL}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b1, scev_pkg::KC_LSHIFT}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b1, scev_pkg::KC_ALT}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b0, scev_pkg::KC_RSHIFT}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, scev_pkg::PREFIX_BYTE, 1'b0);
        queue_word(scev_pkg::MODE_POP, 8'h5A, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, 8'h1C, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, {1'b1, scev_pkg::KC_RSHIFT}, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, scev_pkg::PREFIX_BYTE, 1'b0);
        queue_word(scev_pkg::MODE_CLEAR, 8'h00, 1'b0);
        queue_word(scev_pkg::MODE_BYTE, 8'h51, 1'b0);
        queue_word(scev_pkg::MODE_POP, 8'hFF, 1'b0);
        queue_word(scev_pkg::MODE_POP, 8'h00, 1'b0);

        while (pending_words.size() < ITEMS)
        begin
            if (!flooded && pending_words.size() >= FLOOD_AT)
            begin
                // flood the stack toward its limit while the result side holds off
                flooded = 1'b1;
                queue_word(scev_pkg::MODE_CLEAR, random_byte(), 1'b1);
                flood_start = pending_words.size();
                for (k = 0; k < FLOOD_WORDS; k++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 3)
                        queue_word(scev_pkg::MODE_BYTE, modifier_byte(), 1'b0);
                    else if (pick < 6)
                        queue_word(scev_pkg::MODE_BYTE, scev_pkg::PREFIX_BYTE, 1'b0);
                    else
                        queue_word(scev_pkg::MODE_BYTE, plain_byte(), 1'b0);
                end
                for (k = 0; k < 30; k++)
                    queue_word(scev_pkg::MODE_POP, random_byte(), 1'b0);
                for (k = 0; k < 10; k++)
                    queue_word(scev_pkg::MODE_BYTE, plain_byte(), 1'b0);
                queue_word(scev_pkg::MODE_CLEAR, random_byte(), 1'b0);
            end
            pick = $urandom_range(9);
            if (pick <= 5)
            begin
                seg_len = $urandom_range(30, 8);
                for (k = 0; k < seg_len; k++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 12)
                    begin
                        queue_word(scev_pkg::MODE_BYTE, scev_pkg::PREFIX_BYTE,
                                   (k == 0) && ($urandom_range(9) == 0));
                        case ($urandom_range(3))
                            0:       b = plain_byte();
                            1:       b = modifier_byte();
                            2:       b = scev_pkg::PREFIX_BYTE;
                            default: b = random_byte();
                        endcase
                        queue_word(scev_pkg::MODE_BYTE, b, 1'b0);
                    end
                    else if (pick < 25)
                        queue_word(scev_pkg::MODE_BYTE, modifier_byte(), 1'b0);
                    else if (pick < 60)
                        queue_word(scev_pkg::MODE_BYTE, plain_byte(), 1'b0);
                    else if (pick < 70)
                        queue_word(scev_pkg::MODE_BYTE, random_byte(), 1'b0);
                    else if (pick < 90)
                        queue_word(scev_pkg::MODE_POP, random_byte(), 1'b0);
                    else if (pick < 95)
                        queue_word(scev_pkg::MODE_CLEAR, random_byte(), 1'b0);
                    else
                        queue_word(MODE_UNUSED, random_byte(), 1'b0);
                end
            end
            else if (pick <= 8)
            begin
                seg_len = $urandom_range(16, 4);
                for (k = 0; k < seg_len; k++)
                    queue_word(scev_pkg::MODE_POP, random_byte(), 1'b0);
            end
            else
                queue_word(scev_pkg::MODE_CLEAR, random_byte(), 1'b1);
        end
        total_words = pending_words.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_words.size() != 0 || req_valid || expected_results.size() != 0)
               && idle_cycles < WATCHDOG)
            @(posedge clk);

        if (idle_cycles >= WATCHDOG)
            $display("TEST FAILED");
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (mismatches == 0 && expected_results.size() == 0)
                $display("TEST PASSED");
            else
                $display("TEST FAILED");
        end
        $finish;
    end

endmodule
